// ===== rtl/lidar_point_image_projection_top_macros.svh =====
// Assertion helpers used by the projection top module.
`ifndef LIDAR_POINT_IMAGE_PROJECTION_TOP_MACROS_SVH
`define LIDAR_POINT_IMAGE_PROJECTION_TOP_MACROS_SVH

// same-cycle implication, held off while in reset
`define LPPJ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off while in reset
`define LPPJ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lppj_pkg.sv =====
package lppj_pkg;

  localparam int AccW   = 66;           // row sum, Q32.32 plus growth
  localparam int DenW   = 65;           // positive depth sum magnitude
  localparam int RemW   = AccW + 16;    // |num| << 16
  localparam int CmpW   = DenW + 33;    // den << 32, plus a spare bit
  localparam int NumCells = 32;         // one quotient bit per cell

  localparam int CfgRegs = 8;
  localparam int CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] CFG_ROW0_C01 = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_ROW0_C23 = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_ROW1_C01 = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_ROW1_C23 = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_ROW2_C01 = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_ROW2_C23 = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_WIDTH    = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_HEIGHT   = 3'd7;

  localparam logic [14:0] WIDTH_RST  = 15'd1280;
  localparam logic [14:0] HEIGHT_RST = 15'd720;

  typedef struct packed {
    logic [RemW-1:0] rem;
    logic [31:0]     quo;
    logic            neg;
    logic            ovf;
  } lane_t;

  typedef struct packed {
    lane_t           u;
    lane_t           v;
    logic [DenW-1:0] den;
    logic            pos;
    logic [31:0]     depth;
  } item_t;

endpackage

// ===== rtl/lidar_point_image_projection_top.sv =====
// An accepted input word passes 3 front stages, 32 divider cells and one output register to out_.
// One word per cycle while no finished result waits on out_tready.
// The whole pipeline stalls together only while a finished result waits on out_tready.
// Reset (rst_n low, synchronous): pipeline emptied, coefficients cleared,
// image width 1280 and height 720.
module lidar_point_image_projection_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [95:0]                  in_tdata,   // point_x, point_y, point_z
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [95:0]                  out_tdata,  // pixel_u, pixel_v, depth
  output logic                         out_tuser,  // in_image
  input  logic                         cfg_we,
  input  logic [lppj_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [63:0]                  cfg_wdata
);

  `include "lidar_point_image_projection_top_macros.svh"

  // configuration registers
  logic [5:0][63:0] coef_r;
  logic [14:0]      width_r, height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r   <= '0;
      width_r  <= lppj_pkg::WIDTH_RST;
      height_r <= lppj_pkg::HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        lppj_pkg::CFG_ROW0_C01: coef_r[0] <= cfg_wdata;
        lppj_pkg::CFG_ROW0_C23: coef_r[1] <= cfg_wdata;
        lppj_pkg::CFG_ROW1_C01: coef_r[2] <= cfg_wdata;
        lppj_pkg::CFG_ROW1_C23: coef_r[3] <= cfg_wdata;
        lppj_pkg::CFG_ROW2_C01: coef_r[4] <= cfg_wdata;
        lppj_pkg::CFG_ROW2_C23: coef_r[5] <= cfg_wdata;
        lppj_pkg::CFG_WIDTH:    width_r   <= cfg_wdata[14:0];
        lppj_pkg::CFG_HEIGHT:   height_r  <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  // global advance: moves whenever the output register is free or being drained
  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  logic            chain_v [lppj_pkg::NumCells+1];
  lppj_pkg::item_t chain_d [lppj_pkg::NumCells+1];

  lppj_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .x         (in_tdata[31:0]),
    .y         (in_tdata[63:32]),
    .z         (in_tdata[95:64]),
    .coef      (coef_r),
    .out_valid (chain_v[0]),
    .out_item  (chain_d[0])
  );

  // divider cells, quotient bit 31 first
  for (genvar k = 0; k < lppj_pkg::NumCells; k++) begin : g_cell
    lppj_div_cell #(.SHIFT(lppj_pkg::NumCells - 1 - k)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (chain_v[k]),
      .in_item   (chain_d[k]),
      .out_valid (chain_v[k+1]),
      .out_item  (chain_d[k+1])
    );
  end

  // floor fix-up for negative numerators and saturation to int32
  function automatic logic [31:0] finish(input lppj_pkg::lane_t l);
    logic [32:0] qq;
    if (l.neg) begin
      qq = {1'b0, l.quo} + {32'h0, (l.rem != '0)};
      if (l.ovf || qq > 33'h0_8000_0000) finish = 32'h8000_0000;
      else                               finish = ~qq[31:0] + 32'd1;
    end else begin
      if (l.ovf || l.quo[31]) finish = 32'h7FFF_FFFF;
      else                    finish = l.quo;
    end
  endfunction

  lppj_pkg::item_t last;
  logic [31:0]     u_nxt, v_nxt;
  logic            inside_nxt;
  logic [31:0]     u_lim, v_lim;

  assign last  = chain_d[lppj_pkg::NumCells];
  assign u_lim = {1'b0, width_r, 16'h0};
  assign v_lim = {1'b0, height_r, 16'h0};

  always_comb begin
    u_nxt = last.pos ? finish(last.u) : 32'h0;
    v_nxt = last.pos ? finish(last.v) : 32'h0;
    // bounds are below 2^15, so saturation cannot flip this test
    inside_nxt = last.pos && !u_nxt[31] && !v_nxt[31] && (u_nxt < u_lim) && (v_nxt < v_lim);
  end

  logic        out_valid_r;
  logic [95:0] out_data_r;
  logic        out_user_r;

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= {last.depth, v_nxt, u_nxt};
      out_user_r <= inside_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= chain_v[lppj_pkg::NumCells];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  `LPPJ_ASSERT_IMP(a_inside_nonneg, out_tvalid && out_tuser, !out_tdata[31] && !out_tdata[63], "neg pixel")
  `LPPJ_ASSERT_IMP(a_negdepth_zero, out_tvalid && out_tdata[95], out_tdata[63:0] == 64'h0 && !out_tuser, "neg depth")
  `LPPJ_ASSERT_IMP(a_inside_depth, out_tvalid && out_tuser, !out_tdata[95], "in image, neg depth")

endmodule

// ===== rtl/lppj_front.sv =====
module lppj_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [31:0]          x,
  input  logic [31:0]          y,
  input  logic [31:0]          z,
  input  logic [5:0][63:0]     coef,
  output logic                 out_valid,
  output lppj_pkg::item_t      out_item
);

  logic               va_r, vb_r, vc_r;
  logic signed [63:0] prod_r [9];
  logic signed [lppj_pkg::AccW-1:0] acc_r [3];
  lppj_pkg::item_t    item_r;

  logic signed [lppj_pkg::AccW-1:0] acc_nxt [3];
  lppj_pkg::item_t    item_nxt;

  function automatic logic signed [31:0] half(input logic [63:0] w, input logic hi);
    half = hi ? $signed(w[63:32]) : $signed(w[31:0]);
  endfunction

  function automatic lppj_pkg::lane_t prep(input logic signed [lppj_pkg::AccW-1:0] num,
                                            input logic [lppj_pkg::DenW-1:0] den);
    lppj_pkg::lane_t        l;
    logic [lppj_pkg::AccW-1:0] mag;
    logic [lppj_pkg::CmpW-1:0] nw, dw;
    mag   = num[lppj_pkg::AccW-1] ? (~num + 1'b1) : num;
    l.neg = num[lppj_pkg::AccW-1];
    l.rem = {mag, 16'h0000};
    l.quo = '0;
    nw    = {{(lppj_pkg::CmpW-lppj_pkg::RemW){1'b0}}, l.rem};
    dw    = {1'b0, den, 32'h0};
    l.ovf = (nw >= dw);
    prep  = l;
  endfunction

  // stage A: nine products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        prod_r[3*r]   <= half(coef[2*r], 1'b0) * $signed(x);
        prod_r[3*r+1] <= half(coef[2*r], 1'b1) * $signed(y);
        prod_r[3*r+2] <= half(coef[2*r+1], 1'b0) * $signed(z);
      end
    end
  end

  // stage B: row sums with the offset column aligned to Q32.32
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc_nxt[r] = lppj_pkg::AccW'(prod_r[3*r]) + lppj_pkg::AccW'(prod_r[3*r+1])
                 + lppj_pkg::AccW'(prod_r[3*r+2])
                 + (lppj_pkg::AccW'(half(coef[2*r+1], 1'b1)) <<< 16);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) acc_r[r] <= acc_nxt[r];
    end
  end

  // stage C: depth, signs, magnitudes, quotient overflow
  always_comb begin
    logic signed [49:0] s;
    s             = acc_r[2][lppj_pkg::AccW-1:16];
    item_nxt.pos  = !acc_r[2][lppj_pkg::AccW-1] && (acc_r[2] != '0);
    item_nxt.den  = acc_r[2][lppj_pkg::DenW-1:0];
    if (s[49:31] == '0 || s[49:31] == '1) item_nxt.depth = s[31:0];
    else if (s[49])                       item_nxt.depth = 32'h8000_0000;
    else                                  item_nxt.depth = 32'h7FFF_FFFF;
    item_nxt.u    = prep(acc_r[0], acc_r[2][lppj_pkg::DenW-1:0]);
    item_nxt.v    = prep(acc_r[1], acc_r[2][lppj_pkg::DenW-1:0]);
  end

  always_ff @(posedge clk) begin
    if (en) item_r <= item_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  assign out_valid = vc_r;
  assign out_item  = item_r;

endmodule

// ===== rtl/lppj_div_cell.sv =====
module lppj_div_cell #(
  parameter int SHIFT = 31
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  lppj_pkg::item_t in_item,
  output logic            out_valid,
  output lppj_pkg::item_t out_item
);

  logic            valid_r;
  lppj_pkg::item_t item_r;
  lppj_pkg::item_t item_nxt;

  // one restoring step: take den << SHIFT off the remainder if it fits
  function automatic lppj_pkg::lane_t step(input lppj_pkg::lane_t l,
                                           input logic [lppj_pkg::DenW-1:0] den);
    lppj_pkg::lane_t         o;
    logic [lppj_pkg::CmpW:0] diff;
    logic [lppj_pkg::CmpW-1:0] dsh;
    o    = l;
    dsh  = {{(lppj_pkg::CmpW-lppj_pkg::DenW){1'b0}}, den} << SHIFT;
    diff = {1'b0, {(lppj_pkg::CmpW-lppj_pkg::RemW){1'b0}}, l.rem} - {1'b0, dsh};
    if (!diff[lppj_pkg::CmpW]) begin
      o.rem        = diff[lppj_pkg::RemW-1:0];
      o.quo[SHIFT] = 1'b1;
    end
    step = o;
  endfunction

  always_comb begin
    item_nxt   = in_item;
    item_nxt.u = step(in_item.u, in_item.den);
    item_nxt.v = step(in_item.v, in_item.den);
  end

  always_ff @(posedge clk) begin
    if (en) item_r <= item_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule
